### rtl/psss_pkg.sv
// Package for the power start/stop sequencer: word types, sequencer states,
// command and rating codes, the inverter rating function.
// No dependencies.
package psss_pkg;

  localparam int unsigned VoltW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_BAT_START = 3'd1,
    MODE_INV_WAIT  = 3'd2,
    MODE_WORK      = 3'd3,
    MODE_INV_STOP  = 3'd4,
    MODE_BAT_STOP  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RATE_NA   = 2'd0,
    RATE_OK   = 2'd1,
    RATE_WARN = 2'd2,
    RATE_FAIL = 2'd3
  } rate_e;

  // reported state of battery and inverters
  localparam logic [1:0] UnitIdle    = 2'd0;
  localparam logic [1:0] UnitWorking = 2'd2;

  localparam logic [1:0] KeyStart = 2'd2;
  localparam logic [1:0] KeyStop  = 2'd0;

  localparam logic [CfgIdxW-1:0] RegFailLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWarnLevel = 2'd1;

  typedef struct packed {
    logic [1:0]       key_pos;
    logic             bat_low_charge;
    logic             bat_low_voltage;
    logic [3:0]       hyd_flags;
    logic [3:0]       eng_flags;
    logic [1:0]       battery_state;
    logic [1:0]       hyd_state;
    logic [1:0]       eng_state;
    logic [VoltW-1:0] inverter_voltage;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] start_stage;
    logic       ready_res;
    logic [1:0] hyd_status;
    logic [1:0] eng_status;
    logic [1:0] voltage_status;
    logic [1:0] battery_cmd;
    logic [1:0] inverter_cmd;
    logic       power_hold;
    logic       pump_enable;
  } out_item_t;

  // flags: bit0 online, bit1 error, bit2 warning, bit3 overtemperature
  function automatic rate_e rate_inverter(input logic [3:0] flags);
    rate_e r;
    if (!flags[0]) begin
      r = RATE_NA;
    end else if (flags[1]) begin
      r = RATE_FAIL;
    end else if (flags[2] || flags[3]) begin
      r = RATE_WARN;
    end else begin
      r = RATE_OK;
    end
    return r;
  endfunction

endpackage

### rtl/psss_in_if.sv
// Input channel of the sequencer: valid/ready handshake with one sample word.
// Depends on psss_pkg.
interface psss_in_if;
  logic                 valid;
  logic                 ready;
  psss_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/psss_out_if.sv
// Result channel of the sequencer: valid/ready handshake with one result word.
// Depends on psss_pkg.
interface psss_out_if;
  logic                 valid;
  logic                 ready;
  psss_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/psss_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on psss_pkg.
interface psss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [psss_pkg::CfgIdxW-1:0]    index;
  logic [psss_pkg::CfgDatW-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/power_start_stop_sequencer.sv
// Power start/stop sequencer top level: input register, sequencer decision,
// result register. Depends on psss_pkg, psss_in_if, psss_out_if, psss_cfg_if.

// One sample word is taken per clock cycle and gives exactly one result word.
// A word is held in the input register while the sequencer state, the inverter
// ratings and the voltage rating are worked out from it; they land in the result
// register when that register is free, and the result word is offered from there.
// The throughput of one word per cycle is held as long as the result side takes
// words; a stall on the result side backs up through both registers. Register
// writes are taken in any cycle and must be made while no word is in flight.
module power_start_stop_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  psss_in_if.sink    in_i,
  psss_out_if.source out_o,
  psss_cfg_if.sink   cfg_i
);

  // configuration
  logic [psss_pkg::VoltW-1:0] fail_level_q;
  logic [psss_pkg::VoltW-1:0] warn_level_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_level_q <= '0;
      warn_level_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == psss_pkg::RegFailLevel) begin
        fail_level_q <= cfg_i.wdata;
      end
      if (cfg_i.index == psss_pkg::RegWarnLevel) begin
        warn_level_q <= cfg_i.wdata;
      end
    end
  end

  // pipeline control
  logic                 in_vld_q;
  psss_pkg::in_item_t   in_q;
  logic                 out_vld_q;
  psss_pkg::out_item_t  out_q;
  logic                 out_free;
  logic                 advance;

  assign out_free    = !out_vld_q || out_o.ready;
  assign advance     = in_vld_q && out_free;
  assign in_i.ready  = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // sequencer state
  psss_pkg::mode_e mode_q, mode_d;
  logic            hold_q, hold_d;
  logic            pump_q, pump_d;

  psss_pkg::rate_e hyd_rate, eng_rate, volt_rate;
  psss_pkg::cmd_e  bat_cmd, inv_cmd;
  logic [1:0]      stage;
  logic            ready_now;

  assign hyd_rate  = psss_pkg::rate_inverter(in_q.hyd_flags);
  assign eng_rate  = psss_pkg::rate_inverter(in_q.eng_flags);
  assign ready_now = (hyd_rate == psss_pkg::RATE_OK) && (eng_rate == psss_pkg::RATE_OK)
                     && !in_q.bat_low_charge && !in_q.bat_low_voltage;

  // next state
  always_comb begin
    mode_d = mode_q;
    hold_d = hold_q;
    pump_d = pump_q;
    case (mode_q)
      psss_pkg::MODE_IDLE: begin
        if (in_q.key_pos == psss_pkg::KeyStart && ready_now) begin
          mode_d = psss_pkg::MODE_BAT_START;
        end
      end
      psss_pkg::MODE_BAT_START: begin
        if (in_q.battery_state == psss_pkg::UnitWorking) begin
          mode_d = psss_pkg::MODE_INV_WAIT;
        end
      end
      psss_pkg::MODE_INV_WAIT: begin
        if (in_q.hyd_state == psss_pkg::UnitWorking &&
            in_q.eng_state == psss_pkg::UnitWorking) begin
          mode_d = psss_pkg::MODE_WORK;
          hold_d = 1'b1;
          pump_d = 1'b1;
        end
      end
      psss_pkg::MODE_WORK: begin
        if (in_q.key_pos == psss_pkg::KeyStop) begin
          mode_d = psss_pkg::MODE_INV_STOP;
        end
      end
      psss_pkg::MODE_INV_STOP: begin
        if (in_q.hyd_state == psss_pkg::UnitIdle && in_q.eng_state == psss_pkg::UnitIdle) begin
          mode_d = psss_pkg::MODE_BAT_STOP;
        end
      end
      psss_pkg::MODE_BAT_STOP: begin
        if (in_q.battery_state == psss_pkg::UnitIdle) begin
          mode_d = psss_pkg::MODE_IDLE;
          hold_d = 1'b0;
          pump_d = 1'b0;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  // per-word outputs
  always_comb begin
    bat_cmd = psss_pkg::CMD_NONE;
    inv_cmd = psss_pkg::CMD_NONE;
    stage   = 2'd0;
    case (mode_q)
      psss_pkg::MODE_IDLE: begin
        if (in_q.key_pos == psss_pkg::KeyStart) begin
          stage = 2'd1;
          if (ready_now) begin
            bat_cmd = psss_pkg::CMD_START;
          end
        end
      end
      psss_pkg::MODE_BAT_START: begin
        stage = 2'd2;
        if (in_q.battery_state == psss_pkg::UnitWorking) begin
          inv_cmd = psss_pkg::CMD_START;
        end
      end
      psss_pkg::MODE_INV_WAIT: begin
        stage = 2'd3;
      end
      psss_pkg::MODE_WORK: begin
        if (in_q.key_pos == psss_pkg::KeyStop) begin
          stage   = 2'd3;
          inv_cmd = psss_pkg::CMD_STOP;
        end
      end
      psss_pkg::MODE_INV_STOP: begin
        stage = 2'd2;
        if (in_q.hyd_state == psss_pkg::UnitIdle && in_q.eng_state == psss_pkg::UnitIdle) begin
          bat_cmd = psss_pkg::CMD_STOP;
        end
      end
      psss_pkg::MODE_BAT_STOP: begin
        stage = 2'd1;
      end
      default: begin
        stage = 2'd0;
      end
    endcase
  end

  // voltage is rated against the state after this word; fail test wins
  always_comb begin
    if (mode_d != psss_pkg::MODE_WORK) begin
      volt_rate = psss_pkg::RATE_NA;
    end else if (in_q.inverter_voltage < fail_level_q) begin
      volt_rate = psss_pkg::RATE_FAIL;
    end else if (in_q.inverter_voltage < warn_level_q) begin
      volt_rate = psss_pkg::RATE_WARN;
    end else begin
      volt_rate = psss_pkg::RATE_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= psss_pkg::MODE_IDLE;
      hold_q <= 1'b0;
      pump_q <= 1'b0;
    end else if (advance) begin
      mode_q <= mode_d;
      hold_q <= hold_d;
      pump_q <= pump_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.mode           <= mode_d;
      out_q.start_stage    <= stage;
      out_q.ready_res      <= ready_now;
      out_q.hyd_status     <= hyd_rate;
      out_q.eng_status     <= eng_rate;
      out_q.voltage_status <= volt_rate;
      out_q.battery_cmd    <= bat_cmd;
      out_q.inverter_cmd   <= inv_cmd;
      out_q.power_hold     <= hold_d;
      out_q.pump_enable    <= pump_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

### rtl/psss_checker.sv
// Port-level checks for the power start/stop sequencer, bound to the top level.
// Depends on psss_pkg and power_start_stop_sequencer.
module psss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input psss_pkg::out_item_t out_data_i
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  // hold and pump are switched together
  a_hold_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.power_hold == out_data_i.pump_enable)
    else $error("power hold and pump enable differ");

  // voltage is rated only while working
  a_volt_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.mode == psss_pkg::MODE_WORK) ==
                     (out_data_i.voltage_status != psss_pkg::RATE_NA)))
    else $error("voltage rating does not match working state");

  // battery start only on entry to battery start
  a_bat_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.battery_cmd == psss_pkg::CMD_START
      |-> out_data_i.mode == psss_pkg::MODE_BAT_START)
    else $error("battery start outside battery start state");

  // power hold only from working through battery stop
  a_hold_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.power_hold
      |-> out_data_i.mode == psss_pkg::MODE_WORK ||
          out_data_i.mode == psss_pkg::MODE_INV_STOP ||
          out_data_i.mode == psss_pkg::MODE_BAT_STOP)
    else $error("power hold set outside the powered states");

endmodule

bind power_start_stop_sequencer psss_checker u_psss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

### verif/power_start_stop_sequencer_test.sv
// Testbench for power_start_stop_sequencer: drives sample words with random gaps,
// predicts every result word from its own sequencer model and checks each one.
// Depends on psss_pkg, psss_in_if, psss_out_if, psss_cfg_if and the RTL.
`timescale 1ns / 100ps

module power_start_stop_sequencer_test;
  import psss_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned MaxCycles  = 400000;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseWords = 285;
  localparam int unsigned DrainWait  = 6;

  // Sequencer model plus the queue of result words still owed by the block.
  class sequencer_scoreboard;
    mode_e           mode;
    bit              hold;
    bit              pump;
    logic [15:0]     fail_lvl;
    logic [15:0]     warn_lvl;
    out_item_t       owed[$];
    int              errors;

    function new();
      mode     = MODE_IDLE;
      hold     = 1'b0;
      pump     = 1'b0;
      fail_lvl = '0;
      warn_lvl = '0;
      errors   = 0;
    endfunction

    function void set_level(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == RegFailLevel) begin
        fail_lvl = val;
      end else if (idx == RegWarnLevel) begin
        warn_lvl = val;
      end
    endfunction

    function rate_e grade_inverter(logic [3:0] flags);
      rate_e g;
      casez (flags)
        4'b???0: g = RATE_NA;
        4'b??11: g = RATE_FAIL;
        4'b0001: g = RATE_OK;
        default: g = RATE_WARN;
      endcase
      return g;
    endfunction

    function void note_word(in_item_t w);
      out_item_t e;
      rate_e     hg;
      rate_e     eg;
      bit        rdy;
      e  = '0;
      hg = grade_inverter(w.hyd_flags);
      eg = grade_inverter(w.eng_flags);
      rdy = (hg == RATE_OK) && (eg == RATE_OK) && !w.bat_low_charge && !w.bat_low_voltage;
      e.battery_cmd  = CMD_NONE;
      e.inverter_cmd = CMD_NONE;
      // start_stage is a display step count, not a code
      case (mode)
        MODE_IDLE: begin
          if (w.key_pos == KeyStart) begin
            e.start_stage = 2'd1;
            if (rdy) begin
              e.battery_cmd = CMD_START;
              mode = MODE_BAT_START;
            end
          end
        end
        MODE_BAT_START: begin
          e.start_stage = 2'd2;
          if (w.battery_state == UnitWorking) begin
            e.inverter_cmd = CMD_START;
            mode = MODE_INV_WAIT;
          end
        end
        MODE_INV_WAIT: begin
          e.start_stage = 2'd3;
          if (w.hyd_state == UnitWorking && w.eng_state == UnitWorking) begin
            mode = MODE_WORK;
            hold = 1'b1;
            pump = 1'b1;
          end
        end
        MODE_WORK: begin
          if (w.key_pos == KeyStop) begin
            e.start_stage  = 2'd3;
            e.inverter_cmd = CMD_STOP;
            mode = MODE_INV_STOP;
          end
        end
        MODE_INV_STOP: begin
          e.start_stage = 2'd2;
          if (w.hyd_state == UnitIdle && w.eng_state == UnitIdle) begin
            e.battery_cmd = CMD_STOP;
            mode = MODE_BAT_STOP;
          end
        end
        MODE_BAT_STOP: begin
          e.start_stage = 2'd1;
          if (w.battery_state == UnitIdle) begin
            hold = 1'b0;
            pump = 1'b0;
            mode = MODE_IDLE;
          end
        end
        default: ;
      endcase
      // voltage rated on the state after this tick; fail test wins
      if (mode != MODE_WORK) begin
        e.voltage_status = RATE_NA;
      end else if (w.inverter_voltage < fail_lvl) begin
        e.voltage_status = RATE_FAIL;
      end else if (w.inverter_voltage < warn_lvl) begin
        e.voltage_status = RATE_WARN;
      end else begin
        e.voltage_status = RATE_OK;
      end
      e.mode        = mode;
      e.ready_res   = rdy;
      e.hyd_status  = hg;
      e.eng_status  = eg;
      e.power_hold  = hold;
      e.pump_enable = pump;
      owed.push_back(e);
    endfunction

    function void match_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word %h, expected none", $time, got);
        errors++;
        return;
      end
      e = owed.pop_front();
      match_field("mode", 16'(e.mode), 16'(got.mode));
      match_field("start_stage", 16'(e.start_stage), 16'(got.start_stage));
      match_field("ready_res", 16'(e.ready_res), 16'(got.ready_res));
      match_field("hyd_status", 16'(e.hyd_status), 16'(got.hyd_status));
      match_field("eng_status", 16'(e.eng_status), 16'(got.eng_status));
      match_field("voltage_status", 16'(e.voltage_status), 16'(got.voltage_status));
      match_field("battery_cmd", 16'(e.battery_cmd), 16'(got.battery_cmd));
      match_field("inverter_cmd", 16'(e.inverter_cmd), 16'(got.inverter_cmd));
      match_field("power_hold", 16'(e.power_hold), 16'(got.power_hold));
      match_field("pump_enable", 16'(e.pump_enable), 16'(got.pump_enable));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_cnt;
  int unsigned in_calm;
  int unsigned out_calm;
  sequencer_scoreboard sb;

  psss_in_if  in_if ();
  psss_out_if out_if ();
  psss_cfg_if cfg_if ();

  power_start_stop_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("** power_start_stop_sequencer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.data);
    end
  end

  // random gap before a word, with occasional stretches of back-to-back words
  function automatic int unsigned draw_gap(ref int unsigned calm);
    int unsigned g;
    if (calm > 0) begin
      calm--;
      g = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) begin
        calm = $urandom_range(10, 40);
      end
      g = $urandom_range(0, 6);
    end
    return g;
  endfunction

  function automatic in_item_t mk(logic [1:0] key, logic lc, logic lv, logic [3:0] hf,
                                  logic [3:0] ef, logic [1:0] bs, logic [1:0] hs,
                                  logic [1:0] es, logic [15:0] v);
    in_item_t w;
    w.key_pos          = key;
    w.bat_low_charge   = lc;
    w.bat_low_voltage  = lv;
    w.hyd_flags        = hf;
    w.eng_flags        = ef;
    w.battery_state    = bs;
    w.hyd_state        = hs;
    w.eng_state        = es;
    w.inverter_voltage = v;
    return w;
  endfunction

  function automatic logic [15:0] pick_voltage();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = sb.fail_lvl - 16'd1;
      3: v = sb.fail_lvl;
      4: v = sb.warn_lvl - 16'd1;
      5: v = sb.warn_lvl;
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // Bias the word toward what moves the sequencer on from its current state.
  function automatic in_item_t random_word(mode_e m);
    in_item_t w;
    bit healthy;
    w = mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
           2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_voltage());
    healthy = ($urandom_range(0, 9) < ((m == MODE_IDLE) ? 7 : 4));
    if (healthy) begin
      w.hyd_flags       = 4'b0001;
      w.eng_flags       = 4'b0001;
      w.bat_low_charge  = 1'b0;
      w.bat_low_voltage = 1'b0;
    end
    case (m)
      MODE_IDLE: begin
        if ($urandom_range(0, 9) < 6) w.key_pos = KeyStart;
      end
      MODE_BAT_START: begin
        if ($urandom_range(0, 9) < 4) w.battery_state = UnitWorking;
      end
      MODE_INV_WAIT: begin
        if ($urandom_range(0, 9) < 4) begin
          w.hyd_state = UnitWorking;
          w.eng_state = UnitWorking;
        end
      end
      MODE_WORK: begin
        // stay a while to exercise the voltage rating
        if ($urandom_range(0, 9) < 8 && w.key_pos == KeyStop) w.key_pos = KeyStart;
      end
      MODE_INV_STOP: begin
        if ($urandom_range(0, 9) < 4) begin
          w.hyd_state = UnitIdle;
          w.eng_state = UnitIdle;
        end
      end
      MODE_BAT_STOP: begin
        if ($urandom_range(0, 9) < 4) w.battery_state = UnitIdle;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_word(in_item_t w);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_level(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Lower valid, let every owed word come back, then let the pipe settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_levels(logic [15:0] fail_v, logic [15:0] warn_v);
    write_reg(RegFailLevel, fail_v);
    write_reg(RegWarnLevel, warn_v);
  endtask

  // result side stall, drawn per word
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    in_item_t w;
    sb           = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    cycle_cnt    = 0;
    in_calm      = 0;
    out_calm     = 0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed walk through every state and the not-ready cases
    set_levels(16'd1000, 16'd2000);
    send_word(mk(KeyStart, 0, 0, 4'h0, 4'h1, 0, 0, 0, 16'd0));      // hyd offline
    send_word(mk(KeyStart, 1, 0, 4'h1, 4'h1, 0, 0, 0, 16'd0));      // low charge
    send_word(mk(KeyStart, 0, 1, 4'h1, 4'h1, 0, 0, 0, 16'd0));      // low voltage
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h3, 0, 0, 0, 16'd0));      // traction fail
    send_word(mk(KeyStart, 0, 0, 4'h5, 4'h9, 0, 0, 0, 16'd0));      // warnings
    send_word(mk(2'd1, 0, 0, 4'h1, 4'h1, 0, 0, 0, 16'd0));
    send_word(mk(2'd3, 1, 1, 4'hF, 4'hF, 3, 3, 3, 16'hFFFF));
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 0, 0, 0, 16'd0));      // battery start
    send_word(mk(KeyStop, 0, 0, 4'h1, 4'h1, 1, 0, 0, 16'd0));
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 2, 0, 0, 16'd0));      // inverter start
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 2, 2, 1, 16'd0));
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 2, 1, 2, 16'd0));
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 2, 2, 2, 16'd0));      // working
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 2, 2, 2, 16'd999));
    send_word(mk(KeyStart, 0, 0, 4'h1, 4'h1, 2, 2, 2, 16'd1000));
    send_word(mk(2'd1, 0, 0, 4'h1, 4'h1, 2, 2, 2, 16'd1999));
    send_word(mk(2'd3, 0, 0, 4'h1, 4'h1, 2, 2, 2, 16'd2000));
    send_word(mk(KeyStart, 1, 1, 4'h0, 4'h0, 0, 0, 0, 16'hFFFF));
    send_word(mk(KeyStop, 0, 0, 4'h1, 4'h1, 2, 2, 2, 16'd0));       // key off
    send_word(mk(KeyStop, 0, 0, 4'h1, 4'h1, 2, 0, 3, 16'd0));
    send_word(mk(KeyStop, 0, 0, 4'h1, 4'h1, 2, 0, 0, 16'd0));       // battery stop
    send_word(mk(KeyStop, 0, 0, 4'h1, 4'h1, 3, 0, 0, 16'd0));
    send_word(mk(KeyStop, 0, 0, 4'h1, 4'h1, 0, 0, 0, 16'd0));       // back to idle
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_levels(16'd0, 16'd0);
        1: set_levels(16'hFFFF, 16'hFFFF);
        2: set_levels(16'd40000, 16'd20000);   // levels out of order
        3: set_levels(16'd0, 16'hFFFF);
        default: set_levels(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      for (int i = 0; i < PhaseWords; i++) begin
        w = random_word(sb.mode);
        send_word(w);
      end
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("** power_start_stop_sequencer: PASSED **");
    end else begin
      $display("** power_start_stop_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/psss_pkg.sv
rtl/psss_in_if.sv
rtl/psss_out_if.sv
rtl/psss_cfg_if.sv
rtl/power_start_stop_sequencer.sv
rtl/psss_checker.sv
verif/power_start_stop_sequencer_test.sv
